/* src/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Sizes of the list, command and status codes, and the structs passed
// between the controller and the row of storage cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int DEPTH    = 64;
  localparam int HW       = 32;
  localparam int IW       = $clog2(DEPTH);
  localparam int CW       = $clog2(DEPTH + 1);
  localparam int CMD_W    = 3;
  localparam int POS_W    = 6;
  localparam int HANDLE_W = 32;
  localparam int STAT_W   = 3;
  localparam int FIDX_W   = 6;
  localparam int COUNT_W  = 7;

  typedef logic [HW-1:0] handle_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_SET    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_READ   = 3'd4,
    CMD_FIND   = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADIDX   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic          ins;
    logic          set;
    logic          rem;
    logic          find_mode;
    logic [IW-1:0] pos;
    logic [CW-1:0] len;
    handle_t       h;
  } ile_ctrl_t;

  // Search word handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic          hit;
    handle_t       data;
    logic [IW-1:0] fidx;
  } ile_carry_t;

endpackage

/* src/ile_req_if.sv */
// ----------------------------------------------------------------------------
// ile_req_if: command channel of the indexed list engine
// Valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface ile_req_if import ile_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [POS_W-1:0]    position;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, cmd, position, handle, input ready);
  modport sink   (input valid, cmd, position, handle, output ready);
endinterface

/* src/ile_rsp_if.sv */
// ----------------------------------------------------------------------------
// ile_rsp_if: result channel of the indexed list engine
// Valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface ile_rsp_if import ile_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [HANDLE_W-1:0] data;
  logic [FIDX_W-1:0]   found_index;
  logic [COUNT_W-1:0]  count;
  logic                empty_res;

  modport source (output valid, status, data, found_index, count, empty_res, input ready);
  modport sink   (input valid, status, data, found_index, count, empty_res, output ready);
endinterface

/* src/ile_cell.sv */
// ----------------------------------------------------------------------------
// ile_cell: one storage cell of the list
// Holds one entry, shifts with its neighbors on insert and remove, and
// forwards the search word to the next cell every cycle.
// ----------------------------------------------------------------------------
module ile_cell import ile_pkg::*; (
  input  logic          clk,
  input  logic [IW-1:0] idx,
  input  ile_ctrl_t     ctrl,
  input  handle_t       prev_entry,
  input  handle_t       next_entry,
  input  ile_carry_t    carry_in,
  output handle_t       entry,
  output ile_carry_t    carry_out
);

  logic [CW-1:0] idx_ext;
  logic          hit;

  assign idx_ext = CW'(idx);

  // A find matches on content below the fill level; read and remove match on place.
  assign hit = ctrl.find_mode ? ((entry == ctrl.h) && (idx_ext < ctrl.len))
                              : (idx == ctrl.pos);

  // Insert, set and remove never arrive together, and most cycles carry none.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx == ctrl.pos) begin
        entry <= ctrl.h;
      end else if ((idx > ctrl.pos) && (idx_ext <= ctrl.len)) begin
        entry <= prev_entry;
      end
    end else if (ctrl.set) begin
      if (idx == ctrl.pos) begin
        entry <= ctrl.h;
      end
    end else if (ctrl.rem) begin
      if ((idx >= ctrl.pos) && ((idx_ext + CW'(1)) < ctrl.len)) begin
        entry <= next_entry;
      end
    end
  end

  // The lowest matching cell wins because its word is never overwritten downstream.
  always_ff @(posedge clk) begin
    if (carry_in.hit) begin
      carry_out <= carry_in;
    end else begin
      carry_out <= '{hit: hit, data: entry, fidx: idx};
    end
  end

endmodule

/* src/indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list of element handles
// Flow: append, insert, set, clear and no-op pass through EXEC and DONE;
// read, remove and find also pass through SCAN and POST, while the search word
// crosses the DEPTH-cell chain. A new command is taken only in IDLE, after
// the previous result has been staged in the output register.
// Reset: the fill level and rsp.valid clear, req.ready rises; entries stay undefined.
// ----------------------------------------------------------------------------
module indexed_list_engine import ile_pkg::*; (
  input logic      clk,
  input logic      rst,
  ile_req_if.sink  req,
  ile_rsp_if.source rsp
);

  // Controller states. EXEC checks the command and applies single-cycle
  // updates; SCAN lets the search word ripple through the whole row of
  // cells; POST picks up the search result and performs the remove shift;
  // DONE waits for the output register to be free.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_SCAN = 5'b00100,
    S_POST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t           state;
  cmd_t             cmd_q;
  logic [POS_W-1:0] pos_q;
  handle_t          h_q;
  logic [CW-1:0]    length;
  logic [IW-1:0]    scan_cnt;

  status_t          res_status;
  handle_t          res_data;
  logic [IW-1:0]    res_fidx;

  status_t          chk_status;
  logic             need_scan;
  logic             do_ins;
  logic             do_set;
  logic             do_clr;
  logic [CW-1:0]    pos_ext;
  logic             full;
  logic             h_null;

  ile_ctrl_t        ctrl;
  handle_t          chain_entry [DEPTH];
  ile_carry_t       chain_carry [DEPTH];
  ile_carry_t       last_carry;

  assign req.ready  = (state == S_IDLE);
  assign pos_ext    = CW'(pos_q);
  assign full       = (length >= CW'(DEPTH));
  assign h_null     = (h_q == '0);
  assign last_carry = chain_carry[DEPTH-1];

  // Command checks, evaluated on the latched command while in EXEC.
  // Precedence follows the command definition: null handle first, then
  // index range, then a full list.
  always_comb begin
    chk_status = ST_OK;
    need_scan  = 1'b0;
    do_ins     = 1'b0;
    do_set     = 1'b0;
    do_clr     = 1'b0;
    case (cmd_q)
      CMD_APPEND: begin
        if (h_null) begin
          chk_status = ST_NULL;
        end else if (full) begin
          chk_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_INSERT: begin
        if (h_null) begin
          chk_status = ST_NULL;
        end else if (pos_ext > length) begin
          chk_status = ST_BADIDX;
        end else if (full) begin
          chk_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      CMD_SET: begin
        if (h_null) begin
          chk_status = ST_NULL;
        end else if (pos_ext >= length) begin
          chk_status = ST_BADIDX;
        end else begin
          do_set = 1'b1;
        end
      end
      CMD_REMOVE, CMD_READ: begin
        if (pos_ext >= length) begin
          chk_status = ST_BADIDX;
        end else begin
          need_scan = 1'b1;
        end
      end
      CMD_FIND: begin
        if (h_null) begin
          chk_status = ST_NULL;
        end else begin
          need_scan = 1'b1;
        end
      end
      CMD_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
        chk_status = ST_OK;
      end
    endcase
  end

  // Broadcast to the cells. An append is an insert at the current fill level.
  always_comb begin
    ctrl.ins       = (state == S_EXEC) && do_ins;
    ctrl.set       = (state == S_EXEC) && do_set;
    ctrl.rem       = (state == S_POST) && (cmd_q == CMD_REMOVE);
    ctrl.find_mode = (cmd_q == CMD_FIND);
    ctrl.pos       = (cmd_q == CMD_APPEND) ? IW'(length) : IW'(pos_q);
    ctrl.len       = length;
    ctrl.h         = h_q;
  end

  // The row of cells. Neighbors exchange entries for the shifts, and the
  // search word moves one cell toward the top every cycle.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    handle_t    prev_e;
    handle_t    next_e;
    ile_carry_t cin;

    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign cin    = '0;
    end else begin : g_mid_lo
      assign prev_e = chain_entry[i-1];
      assign cin    = chain_carry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_hi
      assign next_e = chain_entry[i+1];
    end

    ile_cell u_cell (
      .clk        (clk),
      .idx        (IW'(i)),
      .ctrl       (ctrl),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .carry_in   (cin),
      .entry      (chain_entry[i]),
      .carry_out  (chain_carry[i])
    );
  end

  // Controller and result staging.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      length    <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // In DONE the next word takes over the register on the same edge.
      if (rsp.valid && rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q <= cmd_t'(req.cmd);
            pos_q <= req.position;
            h_q   <= HW'(req.handle);
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status <= chk_status;
          res_data   <= '0;
          res_fidx   <= '0;
          if (need_scan) begin
            scan_cnt <= IW'(DEPTH - 1);
            state    <= S_SCAN;
          end else begin
            if (do_ins) begin
              length <= length + CW'(1);
            end else if (do_clr) begin
              length <= '0;
            end
            state <= S_DONE;
          end
        end
        S_SCAN: begin
          // Counting scan_cnt down from DEPTH - 1 lets the search word cross the whole row.
          if (scan_cnt == '0) begin
            state <= S_POST;
          end else begin
            scan_cnt <= scan_cnt - IW'(1);
          end
        end
        S_POST: begin
          if (cmd_q == CMD_FIND) begin
            res_status <= last_carry.hit ? ST_OK : ST_NOTFOUND;
            res_fidx   <= last_carry.hit ? last_carry.fidx : '0;
          end else begin
            res_data <= last_carry.data;
            if (cmd_q == CMD_REMOVE) begin
              length <= length - CW'(1);
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // The output register frees up on the same edge it is taken.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.data        <= HANDLE_W'(res_data);
            rsp.found_index <= FIDX_W'(res_fidx);
            rsp.count       <= COUNT_W'(length);
            rsp.empty_res   <= (length == '0);
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/ile_checker.sv */
// ----------------------------------------------------------------------------
// ile_checker: port-level checks for the indexed list engine
// Watches the command and result channels and flags inconsistent words.
// ----------------------------------------------------------------------------
module ile_checker import ile_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STAT_W-1:0]   rsp_status,
  input logic [HANDLE_W-1:0] rsp_data,
  input logic [FIDX_W-1:0]   rsp_found_index,
  input logic [COUNT_W-1:0]  rsp_count,
  input logic                rsp_empty_res
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data)
      && $stable(rsp_count))
    else $error("result word changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_empty_res == (rsp_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_count <= COUNT_W'(DEPTH)))
    else $error("count beyond list depth");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != ST_OK) |-> (rsp_data == '0) && (rsp_found_index == '0))
    else $error("failed command returned data or index");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command taken while another is in progress");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_data        (rsp.data),
  .rsp_found_index (rsp.found_index),
  .rsp_count       (rsp.count),
  .rsp_empty_res   (rsp.empty_res)
);

/* sim/indexed_list_engine_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine_tb: self-checking bench for the indexed list engine
// A short table of directed commands covers the empty list, null handles, bad
// indexes and list edits. Random traffic follows. It fills the list to the top,
// drains it and mixes edits with reads and finds over a small pool of repeated
// handles. Each result word is checked against a cycle-free list model or its table row.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;
  import ile_pkg::*;

  // Code 7 has no command behind it; the engine must treat it as a no-op.
  localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

  localparam int PLAN_WORDS   = 25;
  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 200;

  typedef enum int {
    MIX_TRAFFIC,
    FILL_TRAFFIC,
    DRAIN_TRAFFIC
  } traffic_mode_t;

  // What one command should produce, at the widths of the result channel.
  typedef struct packed {
    status_t              status;
    handle_t              data;
    logic [FIDX_W-1:0]    fidx;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } list_result_t;

  // One row of the directed table. Where "given" is set, the expected status,
  // data, index and count are written into the row; otherwise the list model
  // supplies them.
  typedef struct packed {
    logic [CMD_W-1:0]     op;
    logic [POS_W-1:0]     pos;
    handle_t              h;
    logic                 given;
    status_t              st;
    handle_t              data;
    logic [FIDX_W-1:0]    fidx;
    logic [COUNT_W-1:0]   cnt;
  } plan_row_t;

  logic clk;
  logic rst;

  ile_req_if req_ch ();
  ile_rsp_if rsp_ch ();

  indexed_list_engine dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list. Only entries below shadow_len are ever read, and
  // each of those has been written, so the undefined storage never matters.
  handle_t      shadow_list [DEPTH];
  int           shadow_len;

  // Recently used handles, so that finds hit and duplicates appear.
  handle_t      handle_pool [16];

  list_result_t awaited_results [$];
  int           words_sent;
  int           results_checked;
  int           failures;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // List model: applies one command to the shadow list and returns the
  // result word it should produce. A failed command leaves the list alone.
  // --------------------------------------------------------------------------
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] op,
                                                      input logic [POS_W-1:0] pos,
                                                      input handle_t h);
    list_result_t r;
    int           i;
    int           p;
    p        = int'(pos);
    r.status = ST_OK;
    r.data   = '0;
    r.fidx   = '0;
    case (op)
      CMD_APPEND: begin
        // A null handle is reported ahead of a full list.
        if (h == '0) r.status = ST_NULL;
        else if (shadow_len >= DEPTH) r.status = ST_FULL;
        else begin
          shadow_list[shadow_len] = h;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        // Null first, then an index past the end, then a full list.
        // Inserting exactly at the end behaves as an append.
        if (h == '0) r.status = ST_NULL;
        else if (p > shadow_len) r.status = ST_BADIDX;
        else if (shadow_len >= DEPTH) r.status = ST_FULL;
        else begin
          for (i = shadow_len; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = h;
          shadow_len++;
        end
      end
      CMD_SET: begin
        if (h == '0) r.status = ST_NULL;
        else if (p >= shadow_len) r.status = ST_BADIDX;
        else shadow_list[p] = h;
      end
      CMD_REMOVE: begin
        if (p >= shadow_len) r.status = ST_BADIDX;
        else begin
          r.data = shadow_list[p];
          for (i = p; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      CMD_READ: begin
        if (p >= shadow_len) r.status = ST_BADIDX;
        else r.data = shadow_list[p];
      end
      CMD_FIND: begin
        // Only the first matching index counts.
        if (h == '0) r.status = ST_NULL;
        else begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < shadow_len && r.status != ST_OK; i++) begin
            if (shadow_list[i] == h) begin
              r.status = ST_OK;
              r.fidx   = i[FIDX_W-1:0];
            end
          end
        end
      end
      CMD_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
      end
    endcase
    r.count = shadow_len[COUNT_W-1:0];
    r.empty = (shadow_len == 0);
    return r;
  endfunction

  // As many handles seen before as fresh ones, plus a few nulls and extremes.
  function automatic handle_t pick_handle();
    int      roll;
    handle_t h;
    roll = $urandom_range(0, 99);
    if (roll < 6) h = '0;
    else if (roll < 50) h = handle_pool[$urandom_range(0, 15)];
    else if (roll < 54) h = '1;
    else if (roll < 56) h = {1'b1, {(HW-1){1'b0}}};
    else begin
      h = $urandom;
      if (h != '0) handle_pool[$urandom_range(0, 15)] = h;
    end
    return h;
  endfunction

  // Draws a command shaped by the traffic mode and the current fill level.
  // Most positions are legal for the command; one in ten is drawn over the
  // whole field so that bad indexes keep turning up.
  task automatic pick_command(input traffic_mode_t mode,
                              output logic [CMD_W-1:0] op,
                              output logic [POS_W-1:0] pos,
                              output handle_t h);
    int roll;
    int mix;
    int top;
    roll = $urandom_range(0, 99);
    mix  = $urandom_range(0, 99);
    if (mode == FILL_TRAFFIC && shadow_len < DEPTH && roll < 85)
      op = (roll < 50) ? CMD_APPEND : CMD_INSERT;
    else if (mode == DRAIN_TRAFFIC && roll < 60)
      op = CMD_REMOVE;
    else if (mix < 20) op = CMD_APPEND;
    else if (mix < 40) op = CMD_INSERT;
    else if (mix < 50) op = CMD_SET;
    else if (mix < 68) op = CMD_REMOVE;
    else if (mix < 80) op = CMD_READ;
    else if (mix < 93) op = CMD_FIND;
    else if (mix < 95) op = CMD_CLEAR;
    else if (mix < 97) op = CMD_NOP;
    else op = 3'($urandom_range(0, 7));

    if ($urandom_range(0, 9) == 0) pos = 6'($urandom_range(0, 63));
    else if (op == CMD_INSERT) begin
      top = (shadow_len > 63) ? 63 : shadow_len;
      pos = 6'($urandom_range(0, top));
    end else if (shadow_len > 0) pos = 6'($urandom_range(0, shadow_len - 1));
    else pos = '0;

    h = pick_handle();
  endtask

  // --------------------------------------------------------------------------
  // Command side. Before each word a gap is drawn at random, except in every
  // fourth stretch of 120 words where words go back to back.
  // Valid is only lowered when a gap is taken, so a word that follows at once
  // keeps valid high through the edge. Once the word is taken, the model is
  // advanced and the result word it predicts is queued.
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [CMD_W-1:0] op,
                           input logic [POS_W-1:0] pos,
                           input handle_t h,
                           input logic use_given,
                           input list_result_t given);
    int           gap;
    list_result_t want;
    gap = (((words_sent / 120) % 4) == 2) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= op;
    req_ch.position <= pos;
    req_ch.handle   <= h;
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
    want = apply_list_command(op, pos, h);
    if (use_given) want = given;
    awaited_results.push_back(want);
  endtask

  task automatic note_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    failures++;
    if (failures <= MAX_REPORTS)
      $error("%s: expected %0h, got %0h (result word %0d)", field, want, got,
             results_checked);
  endtask

  // Compares the result word on the channel with the oldest prediction.
  task automatic check_result_word();
    list_result_t want;
    if (awaited_results.size() == 0) begin
      failures++;
      $error("result word with no command waiting for it: status %0d data %0h",
             rsp_ch.status, rsp_ch.data);
    end else begin
      want = awaited_results.pop_front();
      if (rsp_ch.status !== want.status) note_mismatch("status", want.status, rsp_ch.status);
      if (rsp_ch.data !== want.data) note_mismatch("data", want.data, rsp_ch.data);
      if (rsp_ch.found_index !== want.fidx)
        note_mismatch("found_index", want.fidx, rsp_ch.found_index);
      if (rsp_ch.count !== want.count) note_mismatch("count", want.count, rsp_ch.count);
      if (rsp_ch.empty_res !== want.empty)
        note_mismatch("empty_res", want.empty, rsp_ch.empty_res);
    end
    results_checked++;
  endtask

  // --------------------------------------------------------------------------
  // Result side. Before each word ready may drop for a stall drawn at random,
  // except in every fourth stretch of 100 words. Once, after 400 result words,
  // ready is held low while commands keep coming, so the engine backs up and
  // has to hold off its command channel.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    bit long_hold_done;
    rsp_ch.ready   = 1'b0;
    long_hold_done = 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = (((results_checked / 100) % 4) == 1) ? 0 : $urandom_range(0, 12);
      if (results_checked == 400 && !long_hold_done) begin
        stall          = 300;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      check_result_word();
    end
  end

  // Guards against a hung engine; the limit is several times a slow full run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed table, random traffic, then drain.
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t        plan [PLAN_WORDS];
    list_result_t     given;
    traffic_mode_t    mode;
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    handle_t          h;
    int               k;
    int               span;
    int               roll;
    bit               paused_once;

    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = '0;
    req_ch.position = '0;
    req_ch.handle   = '0;
    shadow_len      = 0;
    words_sent      = 0;
    results_checked = 0;
    failures        = 0;
    paused_once     = 1'b0;
    for (k = 0; k < 16; k++) handle_pool[k] = $urandom | 32'h1;

    // The first rows probe the empty list: every index is bad, and a null
    // handle wins over a bad index. Then a handful of edits build a short
    // list whose contents the model tracks, including an insert at the end,
    // a duplicate handle for find, a set past the end, removal of the last
    // and the first entry, the unused command code and a clear.
    plan = '{
      '{CMD_READ,   6'd0,  32'h0000_0000, 1'b1, ST_BADIDX,   32'h0, 6'd0, 7'd0},
      '{CMD_REMOVE, 6'd63, 32'h0000_0000, 1'b1, ST_BADIDX,   32'h0, 6'd0, 7'd0},
      '{CMD_APPEND, 6'd0,  32'h0000_0000, 1'b1, ST_NULL,     32'h0, 6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  32'h0000_0000, 1'b1, ST_NULL,     32'h0, 6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  32'hFFFF_FFFF, 1'b1, ST_NOTFOUND, 32'h0, 6'd0, 7'd0},
      '{CMD_INSERT, 6'd1,  32'h0000_0005, 1'b1, ST_BADIDX,   32'h0, 6'd0, 7'd0},
      '{CMD_INSERT, 6'd63, 32'h0000_0000, 1'b1, ST_NULL,     32'h0, 6'd0, 7'd0},
      '{CMD_SET,    6'd0,  32'h0000_0007, 1'b1, ST_BADIDX,   32'h0, 6'd0, 7'd0},
      '{CMD_SET,    6'd63, 32'h0000_0000, 1'b1, ST_NULL,     32'h0, 6'd0, 7'd0},
      '{CMD_APPEND, 6'd0,  32'hFFFF_FFFF, 1'b1, ST_OK,       32'h0, 6'd0, 7'd1},
      '{CMD_APPEND, 6'd63, 32'h0000_0001, 1'b1, ST_OK,       32'h0, 6'd0, 7'd2},
      '{CMD_INSERT, 6'd2,  32'h8000_0000, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_INSERT, 6'd0,  32'hA5A5_A5A5, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_INSERT, 6'd1,  32'h5A5A_5A5A, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_READ,   6'd0,  32'h0000_0000, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  32'h0000_0001, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_APPEND, 6'd0,  32'h0000_0001, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_FIND,   6'd0,  32'h0000_0001, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_SET,    6'd2,  32'h1234_5678, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_SET,    6'd6,  32'h0000_0003, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_REMOVE, 6'd5,  32'h0000_0000, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_REMOVE, 6'd0,  32'h0000_0000, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_NOP,    6'd0,  32'h0000_0000, 1'b0, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_CLEAR,  6'd0,  32'h0000_0000, 1'b1, ST_OK,       32'h0, 6'd0, 7'd0},
      '{CMD_READ,   6'd0,  32'h0000_0000, 1'b1, ST_BADIDX,   32'h0, 6'd0, 7'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (k = 0; k < PLAN_WORDS; k++) begin
      given.status = plan[k].st;
      given.data   = plan[k].data;
      given.fidx   = plan[k].fidx;
      given.count  = plan[k].cnt;
      given.empty  = (plan[k].cnt == '0);
      send_word(plan[k].op, plan[k].pos, plan[k].h, plan[k].given, given);
    end

    // Random traffic in episodes. Fill episodes push the list to its top so
    // that appends and inserts run into the full-list error, drain episodes
    // bring it back down, and mixed episodes do a bit of everything.
    while (words_sent < PLAN_WORDS + RANDOM_WORDS) begin
      roll = $urandom_range(0, 9);
      if (roll < 5) mode = MIX_TRAFFIC;
      else if (roll < 8) mode = FILL_TRAFFIC;
      else mode = DRAIN_TRAFFIC;
      span = $urandom_range(20, 90);
      for (k = 0; k < span && words_sent < PLAN_WORDS + RANDOM_WORDS; k++) begin
        // Once, halfway through, stop offering until every result is back,
        // so the engine runs fully empty before traffic resumes.
        if (!paused_once && words_sent >= 900) begin
          req_ch.valid <= 1'b0;
          do @(posedge clk); while (awaited_results.size() != 0);
          paused_once = 1'b1;
        end
        pick_command(mode, op, pos, h);
        send_word(op, pos, h, 1'b0, '0);
      end
    end

    // Let the last results come back, then give a stray word time to show up.
    req_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    if (failures == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/ile_pkg.sv
src/ile_req_if.sv
src/ile_rsp_if.sv
src/ile_cell.sv
src/indexed_list_engine.sv
src/ile_checker.sv
sim/indexed_list_engine_tb.sv
